>>> rtl/core/msis_pkg.sv
// Shared constants and controller/datapath interface types for the increasing-subsequence core.
`default_nettype none

package msis_pkg;

    localparam int SUM_W = 34;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic load;      // take a new request from the input channel
        logic rd_issue;  // read the next stored entry
        logic write;     // store the finished entry
        logic emit;      // load the output register and clear for the next sequence
    } dp_cmd_t;

    typedef struct packed {
        logic full;      // store holds MAX_ITEMS entries
        logic zero;      // store is empty
        logic scan_last; // the read being issued is of the last stored entry
        logic item_last; // the current request closes its sequence
        logic out_free;  // output register can take a result this cycle
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/msis_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module msis_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/msis_ctrl.sv
// Sequencing state machine for the increasing-subsequence core.
`default_nettype none

module msis_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire msis_pkg::dp_status_t status,
    output msis_pkg::dp_cmd_t         cmd
);

    import msis_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.full)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (status.zero)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // The last read's data is compared in this cycle.
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!status.item_last)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/msis_dp.sv
// Datapath: element store, scan compare, running maximum and output register.
`default_nettype none

module msis_dp #(
    parameter int MAX_ITEMS   = 1024,
    parameter int VALUE_WIDTH = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [VALUE_WIDTH-1:0] item_value,
    input  wire logic                   is_last,
    input  wire msis_pkg::dp_cmd_t      cmd,
    output msis_pkg::dp_status_t        status,
    output logic [msis_pkg::SUM_W-1:0]  best_sum,
    output logic                        truncated,
    output logic                        out_valid,
    input  wire logic                   out_ready
);

    import msis_pkg::*;

    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ENT_W  = VALUE_WIDTH + SUM_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

    logic [VALUE_WIDTH-1:0] v_reg;
    logic                   last_reg;
    logic [SUM_W-1:0]       best_reg;
    logic [ADDR_W-1:0]      j_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [SUM_W-1:0]       max_reg;
    logic                   ovf_reg;
    logic                   rd_valid_reg;
    logic                   out_valid_reg;
    logic [SUM_W-1:0]       out_sum_reg;
    logic                   out_trunc_reg;

    logic [ENT_W-1:0]       rd_data;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic [SUM_W-1:0]       rd_sum;
    logic [SUM_W:0]         cand_wide;
    logic [SUM_W-1:0]       cand;

    msis_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({v_reg, best_reg}),
        .re    (cmd.rd_issue),
        .raddr (j_reg),
        .rdata (rd_data)
    );

    assign rd_value  = rd_data[ENT_W-1:SUM_W];
    assign rd_sum    = rd_data[SUM_W-1:0];
    assign cand_wide = {1'b0, rd_sum} + (SUM_W + 1)'(v_reg);
    // Sums saturate at the top of the result range.
    assign cand      = cand_wide[SUM_W] ? SUM_MAX : cand_wide[SUM_W-1:0];

    assign status.full      = (count_reg == CNT_MAX);
    assign status.zero      = (count_reg == '0);
    assign status.scan_last = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign status.item_last = last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg    <= item_value;
            last_reg <= is_last;
            best_reg <= SUM_W'(item_value);
        end
        else if (rd_valid_reg && (rd_value < v_reg) && (cand > best_reg))
        begin
            best_reg <= cand;
        end
        if (cmd.emit)
        begin
            out_sum_reg   <= max_reg;
            out_trunc_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg         <= '0;
            count_reg     <= '0;
            max_reg       <= '0;
            ovf_reg       <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_issue;
            if (cmd.load)
            begin
                j_reg <= '0;
                if (status.full)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            else if (cmd.rd_issue)
            begin
                j_reg <= j_reg + ADDR_W'(1);
            end
            if (cmd.write)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (best_reg > max_reg)
                begin
                    max_reg <= best_reg;
                end
            end
            if (cmd.emit)
            begin
                count_reg     <= '0;
                max_reg       <= '0;
                ovf_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign best_sum  = out_sum_reg;
    assign truncated = out_trunc_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/max_sum_increasing_subsequence_core.sv
// Top level of the maximum-sum strictly increasing subsequence core.
//
// Input channel (in_valid/in_ready): one request per sequence element,
// item_value with is_last set on the final element of a sequence.
// Output channel (out_valid/out_ready): one result per sequence, best_sum
// and truncated, which is set when elements arrived after the store of
// MAX_ITEMS entries was full and were dropped.
// Each element is compared with every earlier stored element through the
// single read port of the element store, one entry a cycle. An accepted
// element passes through the scan, drain, write and finish states, and no
// new element is taken until in_ready rises again; an element that meets
// an empty store skips scan and drain, and one that meets a full store
// goes straight to finish. For a closing element, out_valid rises at the
// same edge as in_ready, provided the output register is free by then.
// The result waits in the output register while the receiver stalls, and
// further requests are still accepted; a second closing element waits in
// its final step until the register has been taken.
// Reset clears the state machine, the element count, the running maximum,
// the overflow flag and the output valid; the store needs no clearing.
`default_nettype none

module max_sum_increasing_subsequence_core #(
    parameter int MAX_ITEMS   = 1024,
    parameter int VALUE_WIDTH = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [VALUE_WIDTH-1:0] item_value,
    input  wire logic                   is_last,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [msis_pkg::SUM_W-1:0]  best_sum,
    output logic                        truncated
);

    import msis_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    msis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    msis_dp #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_value (item_value),
        .is_last    (is_last),
        .cmd        (cmd),
        .status     (status),
        .best_sum   (best_sum),
        .truncated  (truncated),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    // The store is never written past its last entry.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.write |-> !status.full)
        else $error("store written while full");

    // A scan never starts on an empty store.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.rd_issue |-> !status.zero)
        else $error("store read while empty");

    // A result is never loaded over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("result overwritten before delivery");

    // After a request is taken the block works on it before taking another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

endmodule

`default_nettype wire
